/* hw/rtl/fhc_pkg.sv */
`timescale 1ns / 1ps
// fhc_pkg: shared types, widths, register codes and saturation helper
// for the fold / hold / crush audio chain; no dependencies
package fhc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int OFFSET_W = 21;
  localparam int HLEN_W   = 13;
  localparam int SHIFT_W  = 5;
  localparam int CFG_W    = 21;
  localparam int REG_IDX_W = 2;
  localparam int LANES    = 2;
  localparam int WIDE_W   = 27;
  localparam int STEP_W   = 9;
  localparam int STEP_SHIFT = 15;

  localparam logic signed [WIDE_W-1:0] ONE_Q20 = 27'sd1048576;
  localparam logic signed [WIDE_W-1:0] TWO_Q20 = 27'sd2097152;
  localparam logic signed [WIDE_W-1:0] S24_MAX = 27'sd8388607;
  localparam logic signed [WIDE_W-1:0] S24_MIN = -27'sd8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RECT_OFFSET  = 2'd0,
    REG_HOLD_LENGTH  = 2'd1,
    REG_SHIFT_AMOUNT = 2'd2,
    REG_CRUSH_ENABLE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift_amount;
    logic               crush_enable;
  } crush_cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] rect_offset;
    logic [HLEN_W-1:0]   hold_length;
    crush_cfg_t          crush;
  } cfg_t;

  function automatic sample_t sat_s24(input wide_t v);
    sample_t r;
    if (v > S24_MAX) begin
      r = S24_MAX[SAMPLE_W-1:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fold_hold_crush_audio_chain.sv */
`timescale 1ns / 1ps
// fold_hold_crush_audio_chain: top level, config registers, per-lane fold and
// crush, sample-and-hold, output register with skid; depends on fhc_pkg and submodules
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | in_valid in_stall in_left_in ...   | frame in
//  result  | out_valid out_stall out_left_out.. | frame out
//  config  | cfg_wr_en cfg_index cfg_wdata      | write only
//
// one frame per cycle while in_stall is low; the result is registered in the output register, or in the skid entry
// while the output is stalled; the whole chain is one combinational pass into the output register
// a skid register takes one frame while the output is stalled; in_stall
// rises only when that skid entry is full
// synchronous reset clears config (hold length goes to one), hold counter, held samples and valids
module fold_hold_crush_audio_chain #(
  parameter int HOLD_MAX = 4096,
  parameter int CHANNELS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fhc_pkg::sample_t                    in_left_in,
  input  fhc_pkg::sample_t                    in_right_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fhc_pkg::sample_t                    out_left_out,
  output fhc_pkg::sample_t                    out_right_out,
  input  logic                                cfg_wr_en,
  input  logic [fhc_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [fhc_pkg::CFG_W-1:0]           cfg_wdata
);

  fhc_pkg::cfg_t    cfg_r;
  fhc_pkg::sample_t in_frame  [fhc_pkg::LANES];
  fhc_pkg::sample_t folded    [fhc_pkg::LANES];
  fhc_pkg::sample_t held      [fhc_pkg::LANES];
  fhc_pkg::sample_t result    [fhc_pkg::LANES];
  fhc_pkg::sample_t out_data_r  [fhc_pkg::LANES];
  fhc_pkg::sample_t skid_data_r [fhc_pkg::LANES];
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_acc;
  logic             out_free;
  logic             capture;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rect_offset        <= '0;
      cfg_r.hold_length        <= fhc_pkg::HLEN_W'(1);
      cfg_r.crush.shift_amount <= '0;
      cfg_r.crush.crush_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (fhc_pkg::reg_idx_t'(cfg_index))
        fhc_pkg::REG_RECT_OFFSET: begin
          cfg_r.rect_offset <= cfg_wdata[fhc_pkg::OFFSET_W-1:0];
        end
        fhc_pkg::REG_HOLD_LENGTH: begin
          cfg_r.hold_length <= cfg_wdata[fhc_pkg::HLEN_W-1:0];
        end
        fhc_pkg::REG_SHIFT_AMOUNT: begin
          cfg_r.crush.shift_amount <= cfg_wdata[fhc_pkg::SHIFT_W-1:0];
        end
        fhc_pkg::REG_CRUSH_ENABLE: begin
          cfg_r.crush.crush_enable <= cfg_wdata[0];
        end
      endcase
    end
  end

  assign in_frame[0] = in_left_in;
  assign in_frame[1] = in_right_in;

  for (genvar c = 0; c < fhc_pkg::LANES; c++) begin : g_fold
    fhc_fold u_fold (
      .x           (in_frame[c]),
      .rect_offset (cfg_r.rect_offset),
      .y           (folded[c])
    );
  end

  fhc_hold #(
    .HOLD_MAX (HOLD_MAX),
    .CHANNELS (CHANNELS)
  ) u_hold (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_acc),
    .hold_length (cfg_r.hold_length),
    .folded      (folded),
    .held        (held),
    .capture     (capture)
  );

  for (genvar c = 0; c < fhc_pkg::LANES; c++) begin : g_crush
    fhc_crush u_crush (
      .x   (held[c]),
      .cfg (cfg_r.crush),
      .y   (result[c])
    );
  end

  // output register with one skid entry
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= in_acc;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_free) begin
      if (in_acc) begin
        out_data_r <= result;
      end
    end else if (in_acc) begin
      skid_data_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_data_r[0];
  assign out_right_out = out_data_r[1];

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_free) |=> out_valid_r)
    else $error("accepted transaction did not reach output register");

  a_short_hold_captures: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cfg_r.hold_length == fhc_pkg::HLEN_W'(0) ||
                cfg_r.hold_length == fhc_pkg::HLEN_W'(1))) |-> capture)
    else $error("hold length of one did not capture every frame");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("valids not cleared by reset");

endmodule

/* hw/rtl/fhc_fold.sv */
`timescale 1ns / 1ps
// fhc_fold: reflects a sample lying below offset minus one about that point, with saturation
// depends on fhc_pkg
module fhc_fold (
  input  fhc_pkg::sample_t                  x,
  input  logic [fhc_pkg::OFFSET_W-1:0]      rect_offset,
  output fhc_pkg::sample_t                  y
);

  fhc_pkg::wide_t xe;
  fhc_pkg::wide_t oe;
  fhc_pkg::wide_t d;
  fhc_pkg::wide_t r;

  always_comb begin
    xe = fhc_pkg::WIDE_W'(x);
    oe = $signed({{(fhc_pkg::WIDE_W - fhc_pkg::OFFSET_W){1'b0}}, rect_offset});
    d  = xe - oe;
    if (d < -fhc_pkg::ONE_Q20) begin
      r = oe - d - fhc_pkg::TWO_Q20;
    end else begin
      r = xe;
    end
    y = fhc_pkg::sat_s24(r);
  end

endmodule

/* hw/rtl/fhc_crush.sv */
`timescale 1ns / 1ps
// fhc_crush: 1/32-step truncation, wrap to low bits, average with input;
// passes the input through when crush_enable is low; depends on fhc_pkg
module fhc_crush (
  input  fhc_pkg::sample_t   x,
  input  fhc_pkg::crush_cfg_t cfg,
  output fhc_pkg::sample_t   y
);

  fhc_pkg::sample_t                    fl;
  logic signed [fhc_pkg::STEP_W-1:0]   step;
  logic signed [31:0]                  s32;
  logic signed [31:0]                  up;
  logic signed [31:0]                  wrapped;
  logic signed [fhc_pkg::STEP_W-1:0]   w;
  fhc_pkg::wide_t                      sum;

  always_comb begin
    // truncate toward zero: floor, then bump negatives with a remainder
    fl   = x >>> fhc_pkg::STEP_SHIFT;
    step = fl[fhc_pkg::STEP_W-1:0] +
           $signed({{(fhc_pkg::STEP_W-1){1'b0}},
                    (x[fhc_pkg::SAMPLE_W-1] & (|x[fhc_pkg::STEP_SHIFT-1:0]))});
    s32     = 32'(step);
    up      = s32 <<< cfg.shift_amount;
    wrapped = up >>> cfg.shift_amount;
    w       = wrapped[fhc_pkg::STEP_W-1:0];
    sum = $signed({{(fhc_pkg::WIDE_W - fhc_pkg::STEP_W - fhc_pkg::STEP_SHIFT){w[fhc_pkg::STEP_W-1]}},
                   w, {fhc_pkg::STEP_SHIFT{1'b0}}}) + fhc_pkg::WIDE_W'(x);
    if (cfg.crush_enable) begin
      y = fhc_pkg::sat_s24(sum >>> 1);
    end else begin
      y = x;
    end
  end

endmodule

/* hw/rtl/fhc_hold.sv */
`timescale 1ns / 1ps
// fhc_hold: frame counter and held samples for sample-and-hold
// depends on fhc_pkg
module fhc_hold #(
  parameter int HOLD_MAX = 4096,
  parameter int CHANNELS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [fhc_pkg::HLEN_W-1:0]    hold_length,
  input  fhc_pkg::sample_t              folded [fhc_pkg::LANES],
  output fhc_pkg::sample_t              held   [fhc_pkg::LANES],
  output logic                          capture
);

  localparam int CNT_W = $clog2(HOLD_MAX);
  localparam int LEN_W = (CNT_W + 1 > fhc_pkg::HLEN_W) ? CNT_W + 1 : fhc_pkg::HLEN_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] nxt;

  always_comb begin
    len_raw = LEN_W'(hold_length);
    if (len_raw == '0) begin
      len = LEN_W'(1);
    end else if (len_raw > LEN_W'(HOLD_MAX)) begin
      len = LEN_W'(HOLD_MAX);
    end else begin
      len = len_raw;
    end
    nxt       = LEN_W'(count_r) + LEN_W'(1);
    capture   = (nxt >= len);
    count_nxt = capture ? '0 : nxt[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

  for (genvar c = 0; c < fhc_pkg::LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_held
      fhc_pkg::sample_t held_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          held_r <= '0;
        end else if (advance && capture) begin
          held_r <= folded[c];
        end
      end
      assign held[c] = capture ? folded[c] : held_r;
    end else begin : g_pass
      assign held[c] = folded[c];
    end
  end

endmodule

/* verif/tb_fold_hold_crush_audio_chain.sv */
`timescale 1ns / 1ps
// tb_fold_hold_crush_audio_chain: self-checking bench for the fold / hold / crush chain,
// with a built-in frame predictor, random stalls and several register settings
// depends on fhc_pkg and fold_hold_crush_audio_chain
module tb_fold_hold_crush_audio_chain;

  localparam int HOLD_MAX = 4096;
  localparam longint FOLD_UNIT = 1048576;
  localparam int CRUSH_STEP = 32768;
  localparam int QUIET_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 200;

  typedef struct packed {
    fhc_pkg::sample_t left;
    fhc_pkg::sample_t right;
  } frame_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fhc_pkg::sample_t in_left_in = '0;
  fhc_pkg::sample_t in_right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fhc_pkg::sample_t out_left_out;
  fhc_pkg::sample_t out_right_out;
  logic cfg_wr_en = 1'b0;
  logic [fhc_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [fhc_pkg::CFG_W-1:0] cfg_wdata = '0;

  // predictor copy of registers and state
  logic [fhc_pkg::OFFSET_W-1:0] cfg_offset = '0;
  logic [fhc_pkg::HLEN_W-1:0] cfg_hold_len = fhc_pkg::HLEN_W'(1);
  logic [fhc_pkg::SHIFT_W-1:0] cfg_shift = '0;
  logic cfg_crush = 1'b0;
  int unsigned hold_count = 0;
  frame_t held_frame = '0;

  frame_t frames_to_send[$];
  frame_t predicted_outputs[$];
  frame_t send_frame;
  frame_t want;

  int send_idle_pct = 7;
  int recv_idle_pct = 76;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  fold_hold_crush_audio_chain #(
    .HOLD_MAX(HOLD_MAX),
    .CHANNELS(2)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_left_in(in_left_in),
    .in_right_in(in_right_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_left_out(out_left_out),
    .out_right_out(out_right_out),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic fhc_pkg::sample_t clamp_s24(longint v);
    if (v > 8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -8388608) begin
      return 24'sh800000;
    end
    return v[fhc_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic fhc_pkg::sample_t fold_sample(fhc_pkg::sample_t x);
    longint d;
    d = longint'(x) - longint'(cfg_offset);
    if (d < -FOLD_UNIT) begin
      d = -d - 2 * FOLD_UNIT;
    end
    return clamp_s24(d + longint'(cfg_offset));
  endfunction

  function automatic fhc_pkg::sample_t crush_sample(fhc_pkg::sample_t x);
    int step_val;
    int kept;
    longint total;
    step_val = int'(x) / CRUSH_STEP;
    kept = (step_val <<< cfg_shift) >>> cfg_shift;
    total = longint'(kept) * CRUSH_STEP + longint'(x);
    return clamp_s24(total >>> 1);
  endfunction

  function automatic frame_t fold_hold_crush(frame_t f);
    int unsigned span;
    bit capture;
    frame_t r;
    span = cfg_hold_len;
    if (span == 0) begin
      span = 1;
    end
    if (span > HOLD_MAX) begin
      span = HOLD_MAX;
    end
    capture = (hold_count + 1) >= span;
    hold_count = capture ? 0 : hold_count + 1;
    if (capture) begin
      held_frame.left = fold_sample(f.left);
      held_frame.right = fold_sample(f.right);
    end
    r = held_frame;
    if (cfg_crush) begin
      r.left = crush_sample(r.left);
      r.right = crush_sample(r.right);
    end
    return r;
  endfunction

  function automatic fhc_pkg::sample_t pick_sample();
    int v;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? 8388607 : -8388608;
      // around the fold threshold
      1: v = int'(cfg_offset) - 1048576 + int'($urandom_range(8)) - 4;
      2: v = int'($urandom_range(140000)) - 70000;
      // crush step boundaries
      3: v = int'($urandom_range(512)) * CRUSH_STEP - 8388608 + int'($urandom_range(2)) - 1;
      default: v = $urandom;
    endcase
    return v[fhc_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic check_lane(string lane, fhc_pkg::sample_t exp_val, fhc_pkg::sample_t got_val);
    if (got_val !== exp_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, lane, exp_val, got_val);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        send_frame = frames_to_send.pop_front();
        in_valid <= 1'b1;
        in_left_in <= send_frame.left;
        in_right_in <= send_frame.right;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = SQUEEZE_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check, then prediction for the frame taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (predicted_outputs.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, left %0d right %0d", $time,
                   out_left_out, out_right_out);
        end else begin
          want = predicted_outputs.pop_front();
          check_lane("left", want.left, out_left_out);
          check_lane("right", want.right, out_right_out);
        end
      end
      if (in_valid && !in_stall) begin
        quiet_cycles = 0;
        predicted_outputs.push_back(fold_hold_crush({in_left_in, in_right_in}));
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[fold_hold_crush_audio_chain] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(fhc_pkg::reg_idx_t idx, logic [fhc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      fhc_pkg::REG_RECT_OFFSET: cfg_offset = val[fhc_pkg::OFFSET_W-1:0];
      fhc_pkg::REG_HOLD_LENGTH: cfg_hold_len = val[fhc_pkg::HLEN_W-1:0];
      fhc_pkg::REG_SHIFT_AMOUNT: cfg_shift = val[fhc_pkg::SHIFT_W-1:0];
      fhc_pkg::REG_CRUSH_ENABLE: cfg_crush = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_chain(int unsigned offset, int unsigned hold, int unsigned shift,
                           int unsigned crush);
    write_reg(fhc_pkg::REG_RECT_OFFSET, fhc_pkg::CFG_W'(offset));
    write_reg(fhc_pkg::REG_HOLD_LENGTH, fhc_pkg::CFG_W'(hold));
    write_reg(fhc_pkg::REG_SHIFT_AMOUNT, fhc_pkg::CFG_W'(shift));
    write_reg(fhc_pkg::REG_CRUSH_ENABLE, fhc_pkg::CFG_W'(crush));
    @(negedge clk);
  endtask

  task automatic add_frame(int l, int r);
    frame_t f;
    f.left = l[fhc_pkg::SAMPLE_W-1:0];
    f.right = r[fhc_pkg::SAMPLE_W-1:0];
    frames_to_send.push_back(f);
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (frames_to_send.size() != 0 || in_valid || predicted_outputs.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic play_frames(int count, bit squeeze);
    frame_t f;
    for (int i = 0; i < count; i++) begin
      f.left = pick_sample();
      f.right = pick_sample();
      frames_to_send.push_back(f);
    end
    if (squeeze) begin
      hold_asked++;
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: no offset, capture every frame, crusher bypassed
    add_frame(0, -1);
    add_frame(8388607, -8388608);
    add_frame(-8388608, 8388607);
    add_frame(-1048576, -1048577);
    add_frame(-2097152, 1048576);
    drain();

    // largest offset: fold overflow saturates, crusher with zero shift
    set_chain(2097151, 1, 0, 1);
    add_frame(-8388608, -8388607);
    add_frame(8388607, 0);
    add_frame(32767, -32767);
    add_frame(32768, -32768);
    add_frame(-1, 1);
    drain();

    set_chain(1048576, 1, 31, 1);
    add_frame(32768, -32768);
    add_frame(-65537, 65536);
    add_frame(8388607, -8388608);
    add_frame(0, -1048577);
    drain();

    // zero hold length, then a short hold
    set_chain(1048576, 0, 1, 1);
    add_frame(1, 2);
    add_frame(3, 4);
    add_frame(5, 6);
    drain();
    set_chain(0, 3, 1, 0);
    add_frame(10, 20);
    add_frame(30, 40);
    add_frame(50, 60);
    add_frame(70, 80);
    drain();

    set_chain($urandom_range(2097151), 3, 7, 1);
    play_frames(200, 1'b1);
    set_chain(0, 4096, 31, 1);
    play_frames(150, 1'b0);
    set_chain(1048576, 8191, 0, 0);
    play_frames(150, 1'b0);

    @(negedge clk);
    send_idle_pct = 76;
    recv_idle_pct = 7;
    set_chain($urandom_range(2097151), 0, 16, 1);
    play_frames(200, 1'b0);
    set_chain(2097151, 5, 1, 1);
    play_frames(200, 1'b1);
    set_chain(12345, 2, 30, 0);
    play_frames(150, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_chain($urandom_range(2097151), 1, $urandom_range(31), 1);
    play_frames(200, 1'b1);
    set_chain(1048575, 17, 24, 1);
    play_frames(150, 1'b0);
    set_chain($urandom_range(2097151), $urandom_range(1, 64), $urandom_range(31), 1);
    play_frames(150, 1'b0);
    // hold length above the hold ceiling
    set_chain($urandom_range(2097151), 8191, $urandom_range(31), 1);
    play_frames(200, 1'b0);

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("[fold_hold_crush_audio_chain] OK");
    end else begin
      $display("[fold_hold_crush_audio_chain] ERROR");
    end
    $finish;
  end

endmodule
